// ----- design/sorb_pkg.sv -----
package sorb_pkg;

   typedef enum logic [2:0] {
      OP_INSERT   = 3'd0,
      OP_TAKE_SEQ = 3'd1,
      OP_TAKE_SIZE = 3'd2,
      OP_POP_HEAD = 3'd3,
      OP_POP_TAIL = 3'd4,
      OP_PEEK     = 3'd5
   } op_code_type;

   typedef enum logic [1:0] {
      MODE_FIFO = 2'd0,
      MODE_SEQ  = 2'd1,
      MODE_SIZE = 2'd2,
      MODE_BAD  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_APPLY
   } state_type;

   localparam int BYTES_W = 22;
   localparam int COUNT_W = 7;

   typedef struct packed {
      logic [2:0]  op;
      logic [1:0]  buffer_id;
      logic [7:0]  handle;
      logic [15:0] seq_num;
      logic [15:0] byte_len;
      logic [3:0]  harq_id;
      logic [15:0] size_limit;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic [7:0]         handle_out;
      logic [15:0]        seq_out;
      logic [15:0]        size_out;
      logic [3:0]         harq_out;
      logic [COUNT_W-1:0] count;
      logic [BYTES_W-1:0] total_bytes;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  handle;
      logic [15:0] seq;
      logic [15:0] size;
      logic [3:0]  harq;
   } entry_type;

   typedef struct packed {
      logic [15:0] seq;
      logic [15:0] size;
      logic [3:0]  harq;
      logic [15:0] limit;
      logic        by_size;
   } probe_type;

   typedef struct packed {
      logic dup;
      logic gt;
      logic m_seq;
      logic m_size;
   } flags_type;

   typedef struct packed {
      logic load_new;
      logic from_left;
      logic from_right;
   } cmd_type;

endpackage

// ----- design/sorted_pdu_reorder_buffer_top.sv -----
// Keeps NUM_BUFFERS ordered descriptor buffers of CAPACITY entries each, held in
// chains of cells that compare against the request in parallel and shift toward
// the head or tail together. One transaction is in flight at a time: it is
// accepted into a request register, compared in the cell chain, whose flags are
// registered, then applied and its result registered; the apply step waits while
// a held result is stalled. Write sort_mode only while idle.
module sorted_pdu_reorder_buffer_top
   import sorb_pkg::*;
#(
   parameter int NUM_BUFFERS = 4,
   parameter int CAPACITY    = 64,
   parameter int HANDLE_BITS = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [1:0] csr_wdata
);

   localparam int BW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [7:0] HMASK = (HANDLE_BITS >= 8) ? 8'hFF
                                  : 8'((64'd1 << HANDLE_BITS) - 64'd1);

   logic [1:0] mode_ff;
   req_type    req_ff;
   logic       rsp_valid_ff;
   rsp_type    rsp_data_ff, rsp_data_in;

   logic req_accept, apply, ok, emit_new, rsp_busy;
   logic [BW-1:0] bsel;
   logic [CAPACITY-1:0] sel, load_new, from_left, from_right;
   logic [CAPACITY-1:0] row_dup, row_gt, row_m_seq, row_m_size;
   logic [CW-1:0] cnt_out;
   logic [BYTES_W-1:0] bytes_out;

   entry_type cell_q [NUM_BUFFERS][CAPACITY];
   flags_type cell_f [NUM_BUFFERS][CAPACITY];
   entry_type new_entry, sel_entry, out_entry;
   probe_type probe;

   assign rsp_busy = rsp_valid_ff && rsp_stall;

   always_comb begin
      new_entry.handle = req_ff.handle & HMASK;
      new_entry.seq    = req_ff.seq_num;
      new_entry.size   = req_ff.byte_len;
      new_entry.harq   = req_ff.harq_id;
      probe.seq        = req_ff.seq_num;
      probe.size       = req_ff.byte_len;
      probe.harq       = req_ff.harq_id;
      probe.limit      = req_ff.size_limit;
      probe.by_size    = mode_ff == MODE_SIZE;
   end

   for (genvar b = 0; b < NUM_BUFFERS; b++) begin : g_buf
      for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
         cmd_type   cmd;
         entry_type left_e, right_e;
         always_comb begin
            cmd.load_new   = (bsel == BW'(b)) && load_new[i];
            cmd.from_left  = (bsel == BW'(b)) && from_left[i];
            cmd.from_right = (bsel == BW'(b)) && from_right[i];
         end
         if (i == 0) begin : g_first
            assign left_e = '0;
         end else begin : g_mid_l
            assign left_e = cell_q[b][i-1];
         end
         if (i == CAPACITY - 1) begin : g_last
            assign right_e = '0;
         end else begin : g_mid_r
            assign right_e = cell_q[b][i+1];
         end
         sorb_cell u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .probe       (probe),
            .new_entry   (new_entry),
            .left_entry  (left_e),
            .right_entry (right_e),
            .entry       (cell_q[b][i]),
            .flags       (cell_f[b][i])
         );
      end
   end

   always_comb begin
      sel_entry = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         row_dup[i]    = cell_f[bsel][i].dup;
         row_gt[i]     = cell_f[bsel][i].gt;
         row_m_seq[i]  = cell_f[bsel][i].m_seq;
         row_m_size[i] = cell_f[bsel][i].m_size;
         sel_entry     = sel_entry | (sel[i] ? cell_q[bsel][i] : '0);
      end
   end

   sorb_ctrl #(
      .NUM_BUFFERS (NUM_BUFFERS),
      .CAPACITY    (CAPACITY)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_accept (req_accept),
      .rsp_busy   (rsp_busy),
      .req        (req_ff),
      .mode       (mode_ff),
      .row_dup    (row_dup),
      .row_gt     (row_gt),
      .row_m_seq  (row_m_seq),
      .row_m_size (row_m_size),
      .take_size  (sel_entry.size),
      .bsel       (bsel),
      .apply      (apply),
      .ok         (ok),
      .emit_new   (emit_new),
      .sel        (sel),
      .load_new   (load_new),
      .from_left  (from_left),
      .from_right (from_right),
      .cnt_out    (cnt_out),
      .bytes_out  (bytes_out)
   );

   always_comb begin
      out_entry               = emit_new ? new_entry : sel_entry;
      rsp_data_in.ok          = ok;
      rsp_data_in.handle_out  = ok ? out_entry.handle : '0;
      rsp_data_in.seq_out     = ok ? out_entry.seq : '0;
      rsp_data_in.size_out    = ok ? out_entry.size : '0;
      rsp_data_in.harq_out    = ok ? out_entry.harq : '0;
      rsp_data_in.count       = COUNT_W'(cnt_out);
      rsp_data_in.total_bytes = bytes_out;
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req_data;
      end
      if (apply) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_SEQ;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            mode_ff <= csr_wdata;
         end
         if (apply) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.ok |->
         rsp_data_ff.handle_out == '0 && rsp_data_ff.seq_out == '0 &&
         rsp_data_ff.size_out == '0)
      else $error("refused result carries entry data");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> 32'(rsp_data_ff.count) <= CAPACITY)
      else $error("count beyond capacity");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("second transaction accepted while one is in flight");

   a_apply_gated: assert property (@(posedge clock) disable iff (reset)
      apply |-> !rsp_busy)
      else $error("result overwritten while held");

endmodule

// ----- design/sorb_cell.sv -----
module sorb_cell
   import sorb_pkg::*;
(
   input  logic      clock,
   input  cmd_type   cmd,
   input  probe_type probe,
   input  entry_type new_entry,
   input  entry_type left_entry,
   input  entry_type right_entry,
   output entry_type entry,
   output flags_type flags
);

   entry_type entry_ff, entry_in;
   flags_type flags_ff, flags_in;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.load_new) begin
         entry_in = new_entry;
      end else if (cmd.from_left) begin
         entry_in = left_entry;
      end else if (cmd.from_right) begin
         entry_in = right_entry;
      end
   end

   always_comb begin
      flags_in.dup    = entry_ff.seq == probe.seq;
      flags_in.gt     = probe.by_size ? (entry_ff.size > probe.size)
                                      : (entry_ff.seq > probe.seq);
      flags_in.m_seq  = (entry_ff.seq == probe.seq) && (entry_ff.harq == probe.harq);
      flags_in.m_size = entry_ff.size <= probe.limit;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      flags_ff <= flags_in;
   end

   assign entry = entry_ff;
   assign flags = flags_ff;

endmodule

// ----- design/sorb_ctrl.sv -----
module sorb_ctrl
   import sorb_pkg::*;
#(
   parameter int NUM_BUFFERS = 4,
   parameter int CAPACITY    = 64,
   localparam int BW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1,
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                req_accept,
   input  logic                rsp_busy,
   input  req_type             req,
   input  logic [1:0]          mode,
   input  logic [CAPACITY-1:0] row_dup,
   input  logic [CAPACITY-1:0] row_gt,
   input  logic [CAPACITY-1:0] row_m_seq,
   input  logic [CAPACITY-1:0] row_m_size,
   input  logic [15:0]         take_size,
   output logic [BW-1:0]       bsel,
   output logic                apply,
   output logic                ok,
   output logic                emit_new,
   output logic [CAPACITY-1:0] sel,
   output logic [CAPACITY-1:0] load_new,
   output logic [CAPACITY-1:0] from_left,
   output logic [CAPACITY-1:0] from_right,
   output logic [CW-1:0]       cnt_out,
   output logic [BYTES_W-1:0]  bytes_out
);

   state_type state_ff, state_in;
   logic [CW-1:0]      cnt_ff   [NUM_BUFFERS];
   logic [BYTES_W-1:0] bytes_ff [NUM_BUFFERS];

   logic               bvalid;
   logic [CW-1:0]      cur_cnt, nxt_cnt;
   logic [BYTES_W-1:0] cur_bytes, nxt_bytes;
   logic [CAPACITY-1:0] valid, tail, at_cnt, gtv, mseqv, msizev;
   logic [CAPACITY-1:0] first_gt, first_mseq, first_msize, ins_pos, head, ge;
   logic ins_ok, found, remove, do_ins, is_take;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_CMP;
         ST_CMP:   state_in = ST_APPLY;
         ST_APPLY: if (!rsp_busy) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      apply     = 1'b0;
      case (state_ff)
         ST_IDLE:  req_stall = 1'b0;
         ST_APPLY: apply = !rsp_busy;
         default:  req_stall = 1'b1;
      endcase
   end

   assign req_accept = req_valid && !req_stall;

   assign bvalid    = 32'(req.buffer_id) < NUM_BUFFERS;
   assign bsel      = BW'(req.buffer_id);
   assign cur_cnt   = cnt_ff[bsel];
   assign cur_bytes = bytes_ff[bsel];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_pos
      assign valid[i]  = cur_cnt > CW'(i);
      assign at_cnt[i] = cur_cnt == CW'(i);
      assign tail[i]   = cur_cnt == CW'(i + 1);
   end

   always_comb begin
      gtv         = row_gt & valid;
      mseqv       = row_m_seq & valid;
      msizev      = row_m_size & valid;
      first_gt    = gtv & (~gtv + CAPACITY'(1));
      first_mseq  = mseqv & (~mseqv + CAPACITY'(1));
      first_msize = msizev & (~msizev + CAPACITY'(1));
      head        = CAPACITY'(valid[0]);
      ins_pos     = (mode == MODE_FIFO || gtv == '0) ? at_cnt : first_gt;
      case (req.op)
         OP_INSERT:    sel = ins_pos;
         OP_TAKE_SEQ:  sel = first_mseq;
         OP_TAKE_SIZE: sel = first_msize;
         OP_POP_HEAD:  sel = head;
         OP_POP_TAIL:  sel = tail;
         OP_PEEK:      sel = head;
         default:      sel = '0;
      endcase
      is_take = req.op == OP_TAKE_SEQ || req.op == OP_TAKE_SIZE ||
                req.op == OP_POP_HEAD || req.op == OP_POP_TAIL;
      found   = |sel;
      ins_ok  = mode != MODE_BAD && 32'(cur_cnt) < CAPACITY && (row_dup & valid) == '0;
      do_ins  = bvalid && req.op == OP_INSERT && ins_ok;
      remove  = bvalid && is_take && found;
      ok      = do_ins || (bvalid && req.op != OP_INSERT && found);
      ge      = ~(sel - CAPACITY'(1));
   end

   assign emit_new   = do_ins;
   assign load_new   = (apply && do_ins) ? sel : '0;
   assign from_left  = (apply && do_ins) ? (ge & ~sel) : '0;
   assign from_right = (apply && remove) ? ge : '0;

   always_comb begin
      nxt_cnt   = cur_cnt;
      nxt_bytes = cur_bytes;
      if (do_ins) begin
         nxt_cnt   = cur_cnt + CW'(1);
         nxt_bytes = cur_bytes + BYTES_W'(req.byte_len);
      end else if (remove) begin
         nxt_cnt   = cur_cnt - CW'(1);
         nxt_bytes = cur_bytes - BYTES_W'(take_size);
      end
   end

   assign cnt_out   = bvalid ? nxt_cnt : '0;
   assign bytes_out = bvalid ? nxt_bytes : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int b = 0; b < NUM_BUFFERS; b++) begin
            cnt_ff[b]   <= '0;
            bytes_ff[b] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (apply && bvalid) begin
            cnt_ff[bsel]   <= nxt_cnt;
            bytes_ff[bsel] <= nxt_bytes;
         end
      end
   end

endmodule
